FILE: hw/rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppressor.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int EDGE_W   = 16;
    localparam int INDEX_W  = 16;
    localparam int THR_W    = 17;
    localparam int MAXK_W   = 7;
    localparam int TOTAL_W  = 7;
    localparam int SPAN_W   = 17;
    localparam int AREA_W   = 2 * SPAN_W;
    localparam int UNION_W  = AREA_W + 1;
    localparam int PROD_W   = THR_W + UNION_W;
    localparam int FRAC_W   = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [THR_W-1:0]  THR_RESET  = 17'd45875;
    localparam logic [MAXK_W-1:0] MAXK_RESET = 7'd64;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_IOU_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_MAX_KEEP         = 2'd1;
    localparam logic [1:0] REG_INCLUSIVE_COORDS = 2'd2;

    localparam logic signed [EDGE_W+1:0] ONE_PIXEL = 18'sd16;

    typedef logic signed [EDGE_W-1:0] edge_t;

    typedef struct packed {
        edge_t bottom;
        edge_t right;
        edge_t top;
        edge_t left;
    } box_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } gbs_state_t;

    // control from the sequencer to the iou unit
    typedef struct packed {
        logic             en;
        logic             incl;
        logic [THR_W-1:0] thr;
    } cmp_ctrl_t;

    // status back from the iou unit
    typedef struct packed {
        logic busy;
        logic hit;
    } cmp_stat_t;

    // clamped extent from lo to hi, with optional one pixel added
    function automatic logic [SPAN_W-1:0] span(input edge_t lo, input edge_t hi,
                                                input logic incl);
        logic signed [EDGE_W+1:0] d;
        begin
            d = {{2{hi[EDGE_W-1]}}, hi} - {{2{lo[EDGE_W-1]}}, lo}
                + (incl ? ONE_PIXEL : 18'sd0);
            span = (d > 18'sd0) ? d[SPAN_W-1:0] : '0;
        end
    endfunction

endpackage

FILE: hw/rtl/gbs_if.sv
// ----------------------------------------------------------------------------
// gbs_box_if / gbs_res_if
// Valid/ready channels for candidate boxes and for results.
// ----------------------------------------------------------------------------
interface gbs_box_if;
    logic                        valid;
    logic                        ready;
    logic [gbs_pkg::INDEX_W-1:0] box_index;
    gbs_pkg::edge_t              box_left;
    gbs_pkg::edge_t              box_top;
    gbs_pkg::edge_t              box_right;
    gbs_pkg::edge_t              box_bottom;
    logic                        last_box;

    modport source (output valid, box_index, box_left, box_top, box_right, box_bottom,
                    last_box, input ready);
    modport sink   (input valid, box_index, box_left, box_top, box_right, box_bottom,
                    last_box, output ready);
endinterface

interface gbs_res_if;
    logic                        valid;
    logic                        ready;
    logic [gbs_pkg::INDEX_W-1:0] kept_index;
    logic                        kept;
    logic [gbs_pkg::TOTAL_W-1:0] kept_total;
    logic                        set_done;

    modport source (output valid, kept_index, kept, kept_total, set_done, input ready);
    modport sink   (input valid, kept_index, kept, kept_total, set_done, output ready);
endinterface

FILE: hw/rtl/gbs_cell.sv
// ----------------------------------------------------------------------------
// gbs_cell
// One slot of the rotating kept-box ring.
// ----------------------------------------------------------------------------
module gbs_cell (
    input  logic          clk,
    input  logic          shift,
    input  logic          wr_en,
    input  gbs_pkg::box_t wr_box,
    input  gbs_pkg::box_t nb_box,
    output gbs_pkg::box_t box
);
    import gbs_pkg::*;

    box_t box_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_reg <= wr_box;
        end
        else if (shift)
        begin
            box_reg <= nb_box;
        end
    end

    assign box = box_reg;
endmodule

FILE: hw/rtl/gbs_iou.sv
// ----------------------------------------------------------------------------
// gbs_iou
// Pipelined overlap test: inter*65536 >= thr*union, four stages.
// ----------------------------------------------------------------------------
module gbs_iou (
    input  logic              clk,
    input  logic              rst_n,
    input  gbs_pkg::cmp_ctrl_t ctrl,
    input  gbs_pkg::box_t     kept_box,
    input  gbs_pkg::box_t     cand_box,
    output gbs_pkg::cmp_stat_t stat
);
    import gbs_pkg::*;

    logic              s1_en_reg, s2_en_reg, s3_en_reg, s4_hit_reg, s4_en_reg;
    logic [SPAN_W-1:0] wa_reg, ha_reg, wb_reg, hb_reg, wi_reg, hi_reg;
    logic [AREA_W-1:0] area_a_reg, area_b_reg, inter2_reg, inter3_reg;
    logic [UNION_W-1:0] uni_reg;
    logic [THR_W-1:0]  thr1_reg, thr2_reg, thr3_reg;
    edge_t             il, it, ir, ib;
    logic [PROD_W-1:0] rhs, lhs;

    always_comb
    begin
        il = (kept_box.left   > cand_box.left)   ? kept_box.left   : cand_box.left;
        it = (kept_box.top    > cand_box.top)    ? kept_box.top    : cand_box.top;
        ir = (kept_box.right  < cand_box.right)  ? kept_box.right  : cand_box.right;
        ib = (kept_box.bottom < cand_box.bottom) ? kept_box.bottom : cand_box.bottom;
        rhs = thr3_reg * uni_reg;
        lhs = {{(PROD_W-AREA_W-FRAC_W){1'b0}}, inter3_reg, {FRAC_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_en_reg  <= 1'b0;
            s2_en_reg  <= 1'b0;
            s3_en_reg  <= 1'b0;
            s4_en_reg  <= 1'b0;
            s4_hit_reg <= 1'b0;
        end
        else
        begin
            s1_en_reg  <= ctrl.en;
            s2_en_reg  <= s1_en_reg;
            s3_en_reg  <= s2_en_reg;
            s4_en_reg  <= s3_en_reg;
            // zero union never suppresses
            s4_hit_reg <= s3_en_reg && (uni_reg != '0) && (lhs >= rhs);
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg     <= span(kept_box.left, kept_box.right,  ctrl.incl);
        ha_reg     <= span(kept_box.top,  kept_box.bottom, ctrl.incl);
        wb_reg     <= span(cand_box.left, cand_box.right,  ctrl.incl);
        hb_reg     <= span(cand_box.top,  cand_box.bottom, ctrl.incl);
        wi_reg     <= span(il, ir, ctrl.incl);
        hi_reg     <= span(it, ib, ctrl.incl);
        thr1_reg   <= ctrl.thr;
        area_a_reg <= wa_reg * ha_reg;
        area_b_reg <= wb_reg * hb_reg;
        inter2_reg <= wi_reg * hi_reg;
        thr2_reg   <= thr1_reg;
        uni_reg    <= {1'b0, area_a_reg} + {1'b0, area_b_reg} - {1'b0, inter2_reg};
        inter3_reg <= inter2_reg;
        thr3_reg   <= thr2_reg;
    end

    assign stat.busy = s1_en_reg | s2_en_reg | s3_en_reg | s4_en_reg;
    assign stat.hit  = s4_hit_reg;
endmodule

FILE: hw/rtl/greedy_box_suppressor.sv
// ----------------------------------------------------------------------------
// greedy_box_suppressor
// Each request scans the whole kept-box ring, waits for the iou pipeline to
// drain, then forms its result once the result channel is free; one box is in
// flight at a time. The scan feeds the ring into one shared four-stage iou
// unit, one kept box per cycle, and the result side may stall the result.
// A box that arrives once the keep limit is reached skips the scan and goes
// straight to the result stage.
// Reset clears the count, the sequencer and the registers to their defaults;
// the kept-box ring holds no reset.
// ----------------------------------------------------------------------------
module greedy_box_suppressor #(
    parameter int KEEP_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gbs_box_if.sink                     box_in,
    gbs_res_if.source                   result_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [gbs_pkg::DATA_W-1:0]  pwdata,
    output logic [gbs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import gbs_pkg::*;

    localparam int KW = $clog2(KEEP_DEPTH + 1);
    localparam int IW = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
    localparam int CW = (KW > MAXK_W) ? KW : MAXK_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(KEEP_DEPTH);
    localparam logic [IW-1:0] LAST_STEP = IW'(KEEP_DEPTH - 1);

    gbs_state_t         state_reg, state_next;
    logic [THR_W-1:0]   thr_reg;
    logic [MAXK_W-1:0]  max_keep_reg;
    logic               incl_reg;
    logic [KW-1:0]      keep_count_reg, keep_count_next;
    logic [IW-1:0]      step_reg, step_next;
    logic               suppress_reg, suppress_next;
    logic               scan_ok_reg, scan_ok_next;
    box_t               cand_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic               last_reg;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_kept_reg, out_done_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic               accept, shift, keep, finish, cfg_wr;
    logic [CW-1:0]      limit, count_ext;
    cmp_ctrl_t          ctrl;
    cmp_stat_t          stat;
    box_t               cell_box [KEEP_DEPTH];
    box_t               cand_in;

    assign limit     = (CW'(max_keep_reg) < DEPTH_C) ? CW'(max_keep_reg) : DEPTH_C;
    assign count_ext = CW'(keep_count_reg);
    assign accept    = box_in.valid && box_in.ready;
    assign cand_in   = '{bottom: box_in.box_bottom, right: box_in.box_right,
                         top: box_in.box_top, left: box_in.box_left};

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_RESET;
            max_keep_reg <= MAXK_RESET;
            incl_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_IOU_THRESHOLD:    thr_reg      <= pwdata[THR_W-1:0];
                REG_MAX_KEEP:         max_keep_reg <= pwdata[MAXK_W-1:0];
                REG_INCLUSIVE_COORDS: incl_reg     <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IOU_THRESHOLD:    prdata = {{(DATA_W-THR_W){1'b0}}, thr_reg};
            REG_MAX_KEEP:         prdata = {{(DATA_W-MAXK_W){1'b0}}, max_keep_reg};
            REG_INCLUSIVE_COORDS: prdata = {{(DATA_W-1){1'b0}}, incl_reg};
            default:              prdata = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        suppress_next   = suppress_reg | (stat.busy & stat.hit);
        scan_ok_next    = scan_ok_reg;
        keep_count_next = keep_count_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        box_in.ready    = 1'b0;
        shift           = 1'b0;
        keep            = 1'b0;
        finish          = 1'b0;
        ctrl.en         = 1'b0;
        ctrl.incl       = incl_reg;
        ctrl.thr        = thr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                box_in.ready = 1'b1;
                if (box_in.valid)
                begin
                    step_next     = '0;
                    suppress_next = 1'b0;
                    scan_ok_next  = count_ext < limit;
                    state_next    = (count_ext < limit) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                shift     = 1'b1;
                ctrl.en   = CW'(step_reg) < count_ext;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    finish = 1'b1;
                    keep   = scan_ok_reg && !suppress_reg;
                    if (keep)
                    begin
                        keep_count_next = keep_count_reg + 1'b1;
                    end
                    if (keep || last_reg)
                    begin
                        out_valid_next = 1'b1;
                    end
                    if (last_reg)
                    begin
                        keep_count_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            suppress_reg   <= 1'b0;
            scan_ok_reg    <= 1'b0;
            keep_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            suppress_reg   <= suppress_next;
            scan_ok_reg    <= scan_ok_next;
            keep_count_reg <= keep_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg <= cand_in;
            idx_reg  <= box_in.box_index;
            last_reg <= box_in.last_box;
        end
        if (finish)
        begin
            out_index_reg <= keep ? idx_reg : '0;
            out_kept_reg  <= keep;
            out_total_reg <= TOTAL_W'(keep_count_reg + KW'(keep));
            out_done_reg  <= last_reg;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.kept_index = out_index_reg;
    assign result_out.kept       = out_kept_reg;
    assign result_out.kept_total = out_total_reg;
    assign result_out.set_done   = out_done_reg;

    // kept-box ring, slot 0 feeds the iou unit
    for (genvar i = 0; i < KEEP_DEPTH; i++)
    begin : g_ring
        gbs_cell u_cell (
            .clk    (clk),
            .shift  (shift),
            .wr_en  (keep && (keep_count_reg[IW-1:0] == IW'(i))),
            .wr_box (cand_reg),
            .nb_box (cell_box[(i + 1) % KEEP_DEPTH]),
            .box    (cell_box[i])
        );
    end

    gbs_iou u_iou (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .kept_box (cell_box[0]),
        .cand_box (cand_reg),
        .stat     (stat)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(keep_count_reg) <= DEPTH_C)
        else $error("keep count beyond store depth");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !box_in.ready)
        else $error("request accepted while a box is in flight");

    a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && last_reg) |=> (keep_count_reg == '0))
        else $error("count not cleared at end of set");

    a_finish_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !stat.busy)
        else $error("result formed while comparisons outstanding");
endmodule

FILE: bench/greedy_box_suppressor_tb.sv
// ----------------------------------------------------------------------------
// greedy_box_suppressor_tb
// Self-checking bench: directed boxes from a table, register cases, then
// random sets of mostly overlapping boxes, checked against a predictor.
// ----------------------------------------------------------------------------
module greedy_box_suppressor_tb;
    import gbs_pkg::*;

    localparam int DEPTH     = 64;
    localparam int N_RANDOM  = 1530;
    localparam int CYCLE_CAP = 2000000;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        box_t               box;
        logic               last;
    } cand_t;

    typedef struct packed {
        logic [INDEX_W-1:0] kept_index;
        logic               kept;
        logic [TOTAL_W-1:0] kept_total;
        logic               set_done;
    } verdict_t;

    typedef struct {
        cand_t    cand;
        logic     check_typed;
        verdict_t typed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    gbs_box_if box_ch();
    gbs_res_if res_ch();

    greedy_box_suppressor #(.KEEP_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n), .box_in(box_ch.sink), .result_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // predictor state
    box_t              store [DEPTH];
    int unsigned       kept_n;
    logic [THR_W-1:0]  thr_q;
    logic [MAXK_W-1:0] maxk_q;
    logic              incl_q;

    verdict_t pending[$];
    int  errors;
    int  results_seen;
    int  sets_done;
    int  cycles;
    int  send_idle_pct;
    int  recv_stall_pct;

    initial begin
        box_ch.valid = 1'b0;
        box_ch.box_index = '0;
        box_ch.box_left = '0;
        box_ch.box_top = '0;
        box_ch.box_right = '0;
        box_ch.box_bottom = '0;
        box_ch.last_box = 1'b0;
        res_ch.ready = 1'b0;
    end

    function automatic longint extent(longint lo, longint hi, logic incl);
        longint d;
        begin
            d = hi - lo + (incl ? 16 : 0);
            return (d > 0) ? d : 0;
        end
    endfunction

    function automatic bit suppresses(box_t a, box_t b);
        longint aa, ab, ix, iy, inter, uni;
        begin
            aa = extent(a.left, a.right, incl_q) * extent(a.top, a.bottom, incl_q);
            ab = extent(b.left, b.right, incl_q) * extent(b.top, b.bottom, incl_q);
            ix = extent((a.left > b.left) ? a.left : b.left,
                        (a.right < b.right) ? a.right : b.right, incl_q);
            iy = extent((a.top > b.top) ? a.top : b.top,
                        (a.bottom < b.bottom) ? a.bottom : b.bottom, incl_q);
            inter = ix * iy;
            uni = aa + ab - inter;
            if (uni == 0)
                return 1'b0;
            return inter * 65536 >= longint'(thr_q) * uni;
        end
    endfunction

    // greedy suppression step; queues a verdict where one is due
    task automatic predict_nms(input cand_t c);
        int unsigned limit;
        bit keep;
        verdict_t v;
        begin
            limit = (maxk_q < DEPTH) ? maxk_q : DEPTH;
            keep = 1'b0;
            if (kept_n < limit) begin
                keep = 1'b1;
                for (int i = 0; i < kept_n; i++)
                    if (suppresses(store[i], c.box))
                    begin
                        keep = 1'b0;
                        break;
                    end
                if (keep)
                begin
                    store[kept_n] = c.box;
                    kept_n++;
                end
            end
            if (keep || c.last)
            begin
                v.kept_index = keep ? c.index : '0;
                v.kept = keep;
                v.kept_total = kept_n[TOTAL_W-1:0];
                v.set_done = c.last;
                pending.push_back(v);
            end
            if (c.last)
                kept_n = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input verdict_t got, input verdict_t exp);
        begin
            errors++;
            $display({"mismatch %s: got idx=%0d kept=%0b total=%0d done=%0b,",
                      " exp idx=%0d kept=%0b total=%0d done=%0b"},
                     what, got.kept_index, got.kept, got.kept_total, got.set_done,
                     exp.kept_index, exp.kept, exp.kept_total, exp.set_done);
        end
    endtask

    // result side: random stall, compare on acceptance
    always @(posedge clk)
    begin
        verdict_t got;
        if (rst_n)
        begin
            cycles++;
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{res_ch.kept_index, res_ch.kept, res_ch.kept_total, res_ch.set_done};
                results_seen++;
                if (pending.size() == 0)
                    report_mismatch("unexpected", got, '0);
                else if (got !== pending[0])
                    report_mismatch("field", got, pending.pop_front());
                else
                    void'(pending.pop_front());
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= val;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            if (idx == REG_IOU_THRESHOLD) thr_q = val[THR_W-1:0];
            else if (idx == REG_MAX_KEEP) maxk_q = val[MAXK_W-1:0];
            else if (idx == REG_INCLUSIVE_COORDS) incl_q = val[0];
            @(posedge clk);
        end
    endtask

    // let the block drain before touching registers
    task automatic settle;
        begin
            box_ch.valid <= 1'b0;
            @(posedge clk);
            while (pending.size() != 0)
                @(posedge clk);
            repeat (DEPTH + 12) @(posedge clk);
        end
    endtask

    // valid stays high after acceptance until the next request or an idle
    task automatic send_box(input cand_t c);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                box_ch.valid <= 1'b0;
                @(posedge clk);
            end
            box_ch.valid <= 1'b1;
            box_ch.box_index <= c.index;
            box_ch.box_left <= c.box.left;
            box_ch.box_top <= c.box.top;
            box_ch.box_right <= c.box.right;
            box_ch.box_bottom <= c.box.bottom;
            box_ch.last_box <= c.last;
            predict_nms(c);
            @(negedge clk);
            while (!box_ch.ready)
                @(negedge clk);
            @(posedge clk);
            if (c.last) sets_done++;
        end
    endtask

    function automatic cand_t mk(int idx, int l, int t, int r, int b, bit last);
        cand_t c;
        begin
            c.index = idx[INDEX_W-1:0];
            c.box.left = l[15:0];
            c.box.top = t[15:0];
            c.box.right = r[15:0];
            c.box.bottom = b[15:0];
            c.last = last;
            return c;
        end
    endfunction

    function automatic cand_t rand_box(int idx_hint, bit last);
        cand_t c;
        int cx, cy, w, h;
        begin
            if ($urandom_range(9) == 0)
                c = mk($urandom, $urandom, $urandom, $urandom, $urandom, last);
            else
            begin
                // clustered boxes so that overlaps are common
                cx = $urandom_range(400) - 200;
                cy = $urandom_range(400) - 200;
                w = $urandom_range(300);
                h = $urandom_range(300);
                c = mk(idx_hint, cx, cy, cx + w, cy + h, last);
                if ($urandom_range(19) == 0)
                    c.box.right = EDGE_W'(cx - int'($urandom_range(40)));
            end
            return c;
        end
    endfunction

    row_t rows[$];

    task automatic add_row(input cand_t c, input logic typed, input verdict_t v);
        row_t r;
        begin
            r.cand = c;
            r.check_typed = typed;
            r.typed = v;
            rows.push_back(r);
        end
    endtask

    initial
    begin
        int n_sent, set_len, phase;
        logic [DATA_W-1:0] thr_pick [4];
        verdict_t none;
        none = '0;
        errors = 0; results_seen = 0; sets_done = 0; cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        kept_n = 0; thr_q = THR_RESET; maxk_q = MAXK_RESET; incl_q = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first box after reset is always kept; extremes of every edge
        add_row(mk(65535, -32768, -32768, 32767, 32767, 0), 1, '{16'hFFFF, 1, 1, 0});
        add_row(mk(1, -32768, -32768, 32767, 32767, 0), 0, none);
        add_row(mk(2, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(3, 100, 100, 50, 50, 0), 0, none);        // inverted box
        add_row(mk(4, 32767, 32767, -32768, -32768, 0), 0, none);
        add_row(mk(0, 10, 10, 20, 20, 1), 0, none);
        add_row(mk(5, 0, 0, 0, 0, 1), 1, '{5, 1, 1, 1});     // lone zero box
        add_row(mk(6, 0, 0, 160, 160, 0), 1, '{6, 1, 1, 0});
        add_row(mk(7, 0, 0, 160, 160, 1), 1, '{0, 0, 1, 1});  // duplicate, last
        foreach (rows[i])
        begin
            send_box(rows[i].cand);
            if (rows[i].check_typed && rows[i].typed !== pending[$])
                report_mismatch("typed", pending[$], rows[i].typed);
        end
        settle();

        // threshold zero, inclusive, small keep limit
        reg_write(REG_IOU_THRESHOLD, 0);
        reg_write(REG_INCLUSIVE_COORDS, 1);
        reg_write(REG_MAX_KEEP, 2);
        send_box(mk(10, 0, 0, 0, 0, 0));
        send_box(mk(11, 0, 0, 0, 0, 0));
        send_box(mk(12, 500, 500, 600, 600, 0));
        send_box(mk(13, 900, 900, 990, 990, 1));
        settle();
        // threshold of one, keep nothing
        reg_write(REG_IOU_THRESHOLD, 65536);
        reg_write(REG_MAX_KEEP, 0);
        send_box(mk(14, 0, 0, 10, 10, 0));
        send_box(mk(15, 0, 0, 10, 10, 1));
        settle();
        reg_write(REG_MAX_KEEP, 127);
        send_box(mk(16, 0, 0, 10, 10, 0));
        send_box(mk(17, 0, 0, 10, 10, 1));
        settle();

        thr_pick = '{0, 32768, 45875, 65536};
        n_sent = 0;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            settle();
            reg_write(REG_IOU_THRESHOLD, (phase == 5) ? $urandom_range(65536)
                                                      : thr_pick[phase % 4]);
            reg_write(REG_MAX_KEEP, (phase == 2) ? 1 : (phase == 6) ? 64
                                                 : $urandom_range(1, 70));
            reg_write(REG_INCLUSIVE_COORDS, phase[0]);
            while (n_sent < (phase + 1) * N_RANDOM / 8)
            begin
                set_len = ($urandom_range(15) == 0) ? $urandom_range(80, 100)
                                                     : $urandom_range(1, 12);
                for (int k = 0; k < set_len; k++)
                    send_box(rand_box(n_sent + k, k == set_len - 1));
                n_sent += set_len;
                if (phase == 3 && n_sent % 7 == 0)
                begin
                    // hold the sender until the pipeline has emptied
                    box_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (pending.size() != 0)
                        @(posedge clk);
                end
            end
        end

        box_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 12) @(posedge clk);
        $display("covered %0d random boxes in %0d sets, %0d results checked",
                 n_sent, sets_done, results_seen);
        $display("thresholds 0..1.0, keep limits 0..127, both pixel conventions");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: greedy_box_suppressor.f
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_if.sv
hw/rtl/gbs_cell.sv
hw/rtl/gbs_iou.sv
hw/rtl/greedy_box_suppressor.sv
bench/greedy_box_suppressor_tb.sv
